// ===== src/tsas_pkg.sv =====
package tsas_pkg;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int SIZE_W     = 12;
   localparam int ORIENT_W   = 2;
   localparam int PROD_W     = SAMPLE_W + SIZE_W;

   // samples averaged per touch, a power of two so the average is a shift
   localparam int SAMPLES_PER_TOUCH = 16;
   localparam int AVG_SHIFT         = $clog2(SAMPLES_PER_TOUCH);

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [SAMPLE_W-1:0] RAW_MIN_X_RST = 16'd3400;
   localparam logic [SAMPLE_W-1:0] RAW_MAX_X_RST = 16'd29000;
   localparam logic [SAMPLE_W-1:0] RAW_MIN_Y_RST = 16'd3300;
   localparam logic [SAMPLE_W-1:0] RAW_MAX_Y_RST = 16'd30000;
   localparam logic [SIZE_W-1:0]   WIDTH_RST     = 12'd320;
   localparam logic [SIZE_W-1:0]   HEIGHT_RST    = 12'd480;

   // register map, word index
   typedef enum logic [2:0] {
      REG_RAW_MIN_X     = 3'd0,
      REG_RAW_MAX_X     = 3'd1,
      REG_RAW_MIN_Y     = 3'd2,
      REG_RAW_MAX_Y     = 3'd3,
      REG_SCREEN_WIDTH  = 3'd4,
      REG_SCREEN_HEIGHT = 3'd5,
      REG_ORIENTATION   = 3'd6
   } reg_idx_type;

   // orientation codes, naming which axes get mirrored
   typedef enum logic [ORIENT_W-1:0] {
      ORIENT_INV_Y    = 2'd0,
      ORIENT_INV_BOTH = 2'd1,
      ORIENT_INV_X    = 2'd2,
      ORIENT_INV_NONE = 2'd3
   } orient_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] raw_min_x;
      logic [SAMPLE_W-1:0] raw_max_x;
      logic [SAMPLE_W-1:0] raw_min_y;
      logic [SAMPLE_W-1:0] raw_max_y;
      logic [SIZE_W-1:0]   screen_width;
      logic [SIZE_W-1:0]   screen_height;
      orient_type          orientation;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_OFFS,
      ST_MUL,
      ST_SCL_GO,
      ST_SCL_WAIT,
      ST_FIN,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;       // add accepted sample to the run
      logic clear;      // restart the run
      logic load_idle;  // load a no-touch result
      logic load_rsp;   // load the mapped coordinates
      logic axis;       // 0 x, 1 y
      logic scl_start;  // divide the scaled offset by the span
      logic clamp;
      logic offs;
      logic mul;
      logic fin;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_sample;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== src/touch_sample_average_scale.sv =====
// a pen-up transfer gives its no-touch result in the cycle after acceptance
// pen-down samples that do not complete the run are taken one per cycle while the output is free
// the completing sample is mapped for x and then y: clamp, offset, multiply, divide,
// with one restoring divider on the 28-bit product, shared by both axes, one quotient bit a cycle
// a result waiting on the output holds off further sample transfers
// reset (synchronous, active high) restores register defaults and empties the run
module touch_sample_average_scale (
   input  logic        clock,
   input  logic        reset,
   // sample stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_x [15:0], sample_y [31:16]
   input  logic        req_tuser,   // pen_down
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // screen_x [11:0], screen_y [23:12]
   output logic        rsp_tuser,   // touched
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tsas_pkg::cfg_type    cfg;
   tsas_pkg::cmd_type    cmd;
   tsas_pkg::status_type status;
   logic [11:0]          screen_x;
   logic [11:0]          screen_y;

   tsas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .pen_down   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   tsas_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .sample_x     (req_tdata[15:0]),
      .sample_y     (req_tdata[31:16]),
      .rsp_tready   (rsp_tready),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_touched  (rsp_tuser),
      .rsp_screen_x (screen_x),
      .rsp_screen_y (screen_y)
   );

   assign rsp_tdata = {screen_y, screen_x};

endmodule

// ===== src/tsas_csr.sv =====
module tsas_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tsas_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tsas_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tsas_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output tsas_pkg::cfg_type                    cfg
);

   tsas_pkg::cfg_type     cfg_ff;
   tsas_pkg::cfg_type     cfg_in;
   tsas_pkg::reg_idx_type reg_idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = tsas_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tsas_pkg::REG_RAW_MIN_X:     cfg_in.raw_min_x = csr_pwdata[15:0];
            tsas_pkg::REG_RAW_MAX_X:     cfg_in.raw_max_x = csr_pwdata[15:0];
            tsas_pkg::REG_RAW_MIN_Y:     cfg_in.raw_min_y = csr_pwdata[15:0];
            tsas_pkg::REG_RAW_MAX_Y:     cfg_in.raw_max_y = csr_pwdata[15:0];
            tsas_pkg::REG_SCREEN_WIDTH:  cfg_in.screen_width = csr_pwdata[11:0];
            tsas_pkg::REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[11:0];
            tsas_pkg::REG_ORIENTATION:
               cfg_in.orientation = tsas_pkg::orient_type'(csr_pwdata[1:0]);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_min_x     <= tsas_pkg::RAW_MIN_X_RST;
         cfg_ff.raw_max_x     <= tsas_pkg::RAW_MAX_X_RST;
         cfg_ff.raw_min_y     <= tsas_pkg::RAW_MIN_Y_RST;
         cfg_ff.raw_max_y     <= tsas_pkg::RAW_MAX_Y_RST;
         cfg_ff.screen_width  <= tsas_pkg::WIDTH_RST;
         cfg_ff.screen_height <= tsas_pkg::HEIGHT_RST;
         cfg_ff.orientation   <= tsas_pkg::ORIENT_INV_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         tsas_pkg::REG_RAW_MIN_X:     csr_prdata = 32'(cfg_ff.raw_min_x);
         tsas_pkg::REG_RAW_MAX_X:     csr_prdata = 32'(cfg_ff.raw_max_x);
         tsas_pkg::REG_RAW_MIN_Y:     csr_prdata = 32'(cfg_ff.raw_min_y);
         tsas_pkg::REG_RAW_MAX_Y:     csr_prdata = 32'(cfg_ff.raw_max_y);
         tsas_pkg::REG_SCREEN_WIDTH:  csr_prdata = 32'(cfg_ff.screen_width);
         tsas_pkg::REG_SCREEN_HEIGHT: csr_prdata = 32'(cfg_ff.screen_height);
         tsas_pkg::REG_ORIENTATION:   csr_prdata = 32'(cfg_ff.orientation);
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/tsas_div.sv =====
module tsas_div #(
   parameter int DVD_W = 28,
   parameter int DVS_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic             done
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff;
   logic [DVD_W-1:0] quo_in;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] dvs_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [DVS_W:0]   rem_shift;
   logic [DVS_W:0]   rem_diff;
   logic             fits;

   // one restoring step: bring down the next dividend bit
   assign rem_shift = {rem_ff, quo_ff[DVD_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== src/tsas_dp.sv =====
module tsas_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  tsas_pkg::cmd_type                 cmd,
   input  tsas_pkg::cfg_type                 cfg,
   input  logic [tsas_pkg::SAMPLE_W-1:0]     sample_x,
   input  logic [tsas_pkg::SAMPLE_W-1:0]     sample_y,
   input  logic                              rsp_tready,
   output tsas_pkg::status_type              status,
   output logic                              rsp_tvalid,
   output logic                              rsp_touched,
   output logic [tsas_pkg::SIZE_W-1:0]       rsp_screen_x,
   output logic [tsas_pkg::SIZE_W-1:0]       rsp_screen_y
);

   localparam int SW    = tsas_pkg::SAMPLE_W;
   localparam int ZW    = tsas_pkg::SIZE_W;
   localparam int PW    = tsas_pkg::PROD_W;
   localparam int SUM_W = SW + tsas_pkg::AVG_SHIFT;
   localparam int CNT_W = tsas_pkg::AVG_SHIFT;

   logic [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last;

   logic [SW-1:0]    raw_ff, raw_in;
   logic [SW-1:0]    off_ff;
   logic [SW-1:0]    span_ff;
   logic             ok_ff;
   logic [PW-1:0]    prod_ff;
   logic [ZW-1:0]    scr_x_ff;
   logic [ZW-1:0]    scr_y_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_touched_ff;
   logic [ZW-1:0]    rsp_x_ff;
   logic [ZW-1:0]    rsp_y_ff;

   logic [SW-1:0]    lo;
   logic [SW-1:0]    hi;
   logic [ZW-1:0]    size;
   logic [SUM_W-1:0] sum_sel;
   logic             inv_x;
   logic             inv_y;
   logic             inv;
   logic [SW-1:0]    avg;
   logic [ZW-1:0]    scaled;
   logic [ZW-1:0]    mapped;

   logic [PW-1:0]    div_quo;
   logic             div_done;

   // run accumulation
   assign last = cnt_ff == CNT_W'(tsas_pkg::SAMPLES_PER_TOUCH - 1);

   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      cnt_in   = cnt_ff;
      if (cmd.clear) begin
         sum_x_in = '0;
         sum_y_in = '0;
         cnt_in   = '0;
      end else if (cmd.take) begin
         sum_x_in = sum_x_ff + SUM_W'(sample_x);
         sum_y_in = sum_y_ff + SUM_W'(sample_y);
         cnt_in   = last ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         cnt_ff   <= cnt_in;
      end
   end

   // per-axis operand select
   assign inv_x = (cfg.orientation == tsas_pkg::ORIENT_INV_BOTH) ||
                  (cfg.orientation == tsas_pkg::ORIENT_INV_X);
   assign inv_y = (cfg.orientation == tsas_pkg::ORIENT_INV_Y) ||
                  (cfg.orientation == tsas_pkg::ORIENT_INV_BOTH);

   assign lo      = cmd.axis ? cfg.raw_min_y     : cfg.raw_min_x;
   assign hi      = cmd.axis ? cfg.raw_max_y     : cfg.raw_max_x;
   assign size    = cmd.axis ? cfg.screen_height : cfg.screen_width;
   assign sum_sel = cmd.axis ? sum_y_ff          : sum_x_ff;
   assign inv     = cmd.axis ? inv_y             : inv_x;

   // scaling divider, one quotient bit a cycle
   tsas_div #(
      .DVD_W (PW),
      .DVS_W (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.scl_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   // average by shift, then clamp: raise to floor, then lower to ceiling
   assign avg = sum_sel[SUM_W-1:tsas_pkg::AVG_SHIFT];

   always_comb begin
      raw_in = avg;
      if (raw_in < lo) begin
         raw_in = lo;
      end
      if (raw_in > hi) begin
         raw_in = hi;
      end
   end

   // span of zero or less maps to zero before mirroring
   assign scaled = ok_ff ? div_quo[ZW-1:0] : '0;
   assign mapped = inv ? size - scaled : scaled;

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         raw_ff <= raw_in;
      end
      if (cmd.offs) begin
         off_ff  <= raw_ff - lo;
         span_ff <= hi - lo;
         ok_ff   <= hi > lo;
      end
      if (cmd.mul) begin
         prod_ff <= PW'(off_ff) * PW'(size);
      end
      if (cmd.fin && !cmd.axis) begin
         scr_x_ff <= mapped;
      end
      if (cmd.fin && cmd.axis) begin
         scr_y_ff <= mapped;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (cmd.load_idle || cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_idle) begin
         rsp_touched_ff <= 1'b0;
         rsp_x_ff       <= '0;
         rsp_y_ff       <= '0;
      end else if (cmd.load_rsp) begin
         rsp_touched_ff <= 1'b1;
         rsp_x_ff       <= scr_x_ff;
         rsp_y_ff       <= scr_y_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_touched  = rsp_touched_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;

   assign status.last_sample = last;
   assign status.div_done    = div_done;
   assign status.out_free    = ~rsp_valid_ff | rsp_tready;

endmodule

// ===== src/tsas_ctrl.sv =====
module tsas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 pen_down,
   input  tsas_pkg::status_type status,
   output logic                 req_tready,
   output tsas_pkg::cmd_type    cmd
);

   tsas_pkg::state_type state_ff;
   tsas_pkg::state_type state_in;
   logic                axis_ff;
   logic                axis_in;
   logic                ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsas_pkg::ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   // sample intake while idle, then x and y mapped in turn
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      ready    = 1'b0;
      unique case (state_ff)
         tsas_pkg::ST_IDLE: begin
            ready = status.out_free;
            if (req_tvalid && ready) begin
               if (!pen_down) begin
                  cmd.clear     = 1'b1;
                  cmd.load_idle = 1'b1;
               end else begin
                  cmd.take = 1'b1;
                  if (status.last_sample) begin
                     axis_in  = 1'b0;
                     state_in = tsas_pkg::ST_CLAMP;
                  end
               end
            end
         end
         tsas_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = tsas_pkg::ST_OFFS;
         end
         tsas_pkg::ST_OFFS: begin
            cmd.offs = 1'b1;
            state_in = tsas_pkg::ST_MUL;
         end
         tsas_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = tsas_pkg::ST_SCL_GO;
         end
         tsas_pkg::ST_SCL_GO: begin
            cmd.scl_start = 1'b1;
            state_in      = tsas_pkg::ST_SCL_WAIT;
         end
         tsas_pkg::ST_SCL_WAIT: begin
            if (status.div_done) begin
               state_in = tsas_pkg::ST_FIN;
            end
         end
         tsas_pkg::ST_FIN: begin
            cmd.fin = 1'b1;
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = tsas_pkg::ST_CLAMP;
            end else begin
               state_in = tsas_pkg::ST_OUT;
            end
         end
         tsas_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = tsas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsas_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = ready;

endmodule

// ===== src/tsas_checker.sv =====
module tsas_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // result stream is empty right after reset
   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a no-touch result carries zero coordinates
   a_untouched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("no-touch result with nonzero coordinates");

   // a pen-up transfer is answered by a no-touch result in the next cycle
   a_pen_up_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> rsp_tvalid && !rsp_tuser)
      else $error("pen-up transfer not answered");

endmodule

bind touch_sample_average_scale tsas_checker u_tsas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
